FILE: rtl/cmfs_pkg.sv
package cmfs_pkg;

    // Field widths of the channels
    localparam int DIR_W  = 16;
    localparam int FACE_W = 3;
    localparam int TEX_W  = 16;

    // Arithmetic widths
    localparam int COORD_BITS = 16;
    localparam int UV_BITS    = 16;
    localparam int MAG_W      = COORD_BITS;       // |c| up to 2^(COORD_BITS-1)
    localparam int NUM_W      = COORD_BITS + 1;   // c + m up to 2m
    localparam int EXT_W      = COORD_BITS + 2;   // signed room for m - c
    localparam int QUO_W      = UV_BITS + 1;      // raw quotient floor(N * 2^UV / m)
    localparam int DIV_STAGES = QUO_W;            // one quotient bit per stage

    localparam logic [UV_BITS-1:0] UV_MID = UV_BITS'(1) << (UV_BITS - 1);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [FACE_W-1:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_t;

    // Classified item handed from front to back
    typedef struct packed {
        face_t            face;
        logic             degenerate;
        logic [MAG_W-1:0] mag;
        logic [NUM_W-1:0] num_u;
        logic [NUM_W-1:0] num_v;
    } cmfs_job_t;

    // One divider stage's state
    typedef struct packed {
        face_t            face;
        logic             degenerate;
        logic [MAG_W-1:0] mag;
        logic [NUM_W-1:0] rem_u;
        logic [NUM_W-1:0] rem_v;
        logic [QUO_W-1:0] quo_u;
        logic [QUO_W-1:0] quo_v;
    } cmfs_div_t;

endpackage

FILE: rtl/cmfs_dir_if.sv
interface cmfs_dir_if;
    import cmfs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;

    modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

FILE: rtl/cmfs_tex_if.sv
interface cmfs_tex_if;
    import cmfs_pkg::*;

    logic              valid;
    logic              ready;
    logic [FACE_W-1:0] face;
    logic [TEX_W-1:0]  tex_u;
    logic [TEX_W-1:0]  tex_v;
    logic              degenerate;

    modport source (output valid, output face, output tex_u, output tex_v,
                    output degenerate, input ready);
    modport sink   (input valid, input face, input tex_u, input tex_v,
                    input degenerate, output ready);
endinterface

FILE: rtl/cmfs_front.sv
module cmfs_front (
    input  logic                clk,
    input  logic                rst_n,
    cmfs_dir_if.sink            dir,
    output logic                job_valid,
    input  logic                job_ready,
    output cmfs_pkg::cmfs_job_t job
);
    import cmfs_pkg::*;

    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic [MAG_W-1:0]             ax;
    logic [MAG_W-1:0]             ay;
    logic [MAG_W-1:0]             az;
    logic signed [EXT_W-1:0]      xe;
    logic signed [EXT_W-1:0]      ye;
    logic signed [EXT_W-1:0]      ze;
    logic signed [EXT_W-1:0]      me;
    logic signed [EXT_W-1:0]      ue;
    logic signed [EXT_W-1:0]      ve;
    logic [MAG_W-1:0]             mag;
    logic                         sel_x;
    logic                         sel_y;
    logic                         degen;
    face_t                        face;
    cmfs_job_t                    job_next;
    cmfs_job_t                    job_reg;
    logic                         valid_reg;

    function automatic logic [MAG_W-1:0] magnitude(input logic signed [COORD_BITS-1:0] v);
        // -most_negative wraps to the right unsigned pattern
        return v[COORD_BITS-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    assign x  = dir.dir_x[COORD_BITS-1:0];
    assign y  = dir.dir_y[COORD_BITS-1:0];
    assign z  = dir.dir_z[COORD_BITS-1:0];
    assign ax = magnitude(x);
    assign ay = magnitude(y);
    assign az = magnitude(z);
    assign xe = EXT_W'(x);
    assign ye = EXT_W'(y);
    assign ze = EXT_W'(z);

    always_comb
    begin
        degen = (ax == '0) && (ay == '0) && (az == '0);
        sel_x = (ax >= ay) && (ax >= az);
        sel_y = !sel_x && (ay >= az);
        mag   = az;
        face  = FACE_POS_Z;
        ue    = '0;
        ve    = '0;
        if (sel_x)
        begin
            mag = ax;
        end
        else if (sel_y)
        begin
            mag = ay;
        end
        me = EXT_W'(mag);
        // numerators are c + m, always in 0..2m
        if (sel_x)
        begin
            ve = me + ye;
            if (x > 0)
            begin
                face = FACE_POS_X;
                ue   = me - ze;
            end
            else
            begin
                face = FACE_NEG_X;
                ue   = me + ze;
            end
        end
        else if (sel_y)
        begin
            ue = me + xe;
            if (y > 0)
            begin
                face = FACE_POS_Y;
                ve   = me - ze;
            end
            else
            begin
                face = FACE_NEG_Y;
                ve   = me + ze;
            end
        end
        else
        begin
            ve = me + ye;
            if (z > 0)
            begin
                face = FACE_POS_Z;
                ue   = me + xe;
            end
            else
            begin
                face = FACE_NEG_Z;
                ue   = me - xe;
            end
        end
        if (degen)
        begin
            face = FACE_POS_X;
        end
        job_next.face       = face;
        job_next.degenerate = degen;
        job_next.mag        = mag;
        job_next.num_u      = ue[NUM_W-1:0];
        job_next.num_v      = ve[NUM_W-1:0];
    end

    assign dir.ready = !valid_reg || job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (dir.ready)
        begin
            valid_reg <= dir.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dir.valid && dir.ready)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = valid_reg;
    assign job       = job_reg;

endmodule

FILE: rtl/cmfs_queue.sv
module cmfs_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cmfs_pkg::cmfs_job_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cmfs_pkg::cmfs_job_t out_data
);
    import cmfs_pkg::*;

    cmfs_job_t               mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg;
    logic [QUEUE_AW-1:0]     wr_ptr_next;
    logic [QUEUE_AW-1:0]     rd_ptr_reg;
    logic [QUEUE_AW-1:0]     rd_ptr_next;
    logic [QUEUE_CW-1:0]     count_reg;
    logic [QUEUE_CW-1:0]     count_next;
    logic                    push;
    logic                    pop;

    assign in_ready  = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: rtl/cmfs_back.sv
module cmfs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_ready,
    input  cmfs_pkg::cmfs_job_t job,
    cmfs_tex_if.source          tex
);
    import cmfs_pkg::*;

    cmfs_div_t          stage_src   [DIV_STAGES];
    logic               src_vld     [DIV_STAGES];
    cmfs_div_t          stage_next  [DIV_STAGES];
    cmfs_div_t          stage_reg   [DIV_STAGES];
    logic               stage_vld_reg [DIV_STAGES];

    logic               advance;
    cmfs_div_t          last;
    logic [QUO_W:0]     sum_u;
    logic [QUO_W:0]     sum_v;
    logic [QUO_W-1:0]   rnd_u;
    logic [QUO_W-1:0]   rnd_v;
    logic [UV_BITS-1:0] coord_u;
    logic [UV_BITS-1:0] coord_v;

    logic               out_valid_reg;
    face_t              face_reg;
    logic [TEX_W-1:0]   tex_u_reg;
    logic [TEX_W-1:0]   tex_v_reg;
    logic               degenerate_reg;

    // whole pipe moves together whenever the output slot frees up
    assign advance   = !out_valid_reg || tex.ready;
    assign job_ready = advance;

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        logic [NUM_W-1:0] dvs;
        logic             fit_u;
        logic             fit_v;

        if (i == 0)
        begin : g_first
            always_comb
            begin
                stage_src[i].face       = job.face;
                stage_src[i].degenerate = job.degenerate;
                stage_src[i].mag        = job.mag;
                stage_src[i].rem_u      = job.num_u;
                stage_src[i].rem_v      = job.num_v;
                stage_src[i].quo_u      = '0;
                stage_src[i].quo_v      = '0;
            end
            assign src_vld[i] = job_valid;
        end
        else
        begin : g_rest
            always_comb
            begin
                stage_src[i]       = stage_reg[i-1];
                stage_src[i].rem_u = {stage_reg[i-1].rem_u[NUM_W-2:0], 1'b0};
                stage_src[i].rem_v = {stage_reg[i-1].rem_v[NUM_W-2:0], 1'b0};
            end
            assign src_vld[i] = stage_vld_reg[i-1];
        end

        // restoring step: one quotient bit for u and for v
        assign dvs   = {1'b0, stage_src[i].mag};
        assign fit_u = (stage_src[i].rem_u >= dvs);
        assign fit_v = (stage_src[i].rem_v >= dvs);

        always_comb
        begin
            stage_next[i]       = stage_src[i];
            stage_next[i].rem_u = fit_u ? stage_src[i].rem_u - dvs : stage_src[i].rem_u;
            stage_next[i].rem_v = fit_v ? stage_src[i].rem_v - dvs : stage_src[i].rem_v;
            stage_next[i].quo_u = {stage_src[i].quo_u[QUO_W-2:0], fit_u};
            stage_next[i].quo_v = {stage_src[i].quo_v[QUO_W-2:0], fit_v};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_vld_reg[i] <= 1'b0;
            end
            else if (advance)
            begin
                stage_vld_reg[i] <= src_vld[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance && src_vld[i])
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    // round half up: (floor(N*2^UV/m) + 1) / 2, then saturate
    assign last    = stage_reg[DIV_STAGES-1];
    assign sum_u   = {1'b0, last.quo_u} + (QUO_W+1)'(1);
    assign sum_v   = {1'b0, last.quo_v} + (QUO_W+1)'(1);
    assign rnd_u   = sum_u[QUO_W:1];
    assign rnd_v   = sum_v[QUO_W:1];
    assign coord_u = rnd_u[UV_BITS] ? '1 : rnd_u[UV_BITS-1:0];
    assign coord_v = rnd_v[UV_BITS] ? '1 : rnd_v[UV_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage_vld_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_vld_reg[DIV_STAGES-1])
        begin
            face_reg       <= last.face;
            degenerate_reg <= last.degenerate;
            tex_u_reg      <= last.degenerate ? TEX_W'(UV_MID) : TEX_W'(coord_u);
            tex_v_reg      <= last.degenerate ? TEX_W'(UV_MID) : TEX_W'(coord_v);
        end
    end

    assign tex.valid      = out_valid_reg;
    assign tex.face       = face_reg;
    assign tex.tex_u      = tex_u_reg;
    assign tex.tex_v      = tex_v_reg;
    assign tex.degenerate = degenerate_reg;

endmodule

FILE: rtl/cube_map_face_uv_select_unit.sv
// Path: a dir beat passes through 1 front register, 1 queue slot, 17 divider stages
//   and 1 output register before it is taken as a tex beat; a tex stall holds the
//   back pipe in place.
// Throughput: one beat per cycle while tex does not stall; the 17-stage pipelined divider,
//   one quotient bit per stage for u and v side by side, takes a new item every cycle it advances.
// Reset: rst_n async, active low; clears valid flags, queue pointers and count.
//   Payload registers are not reset.
module cube_map_face_uv_select_unit (
    input  logic       clk,
    input  logic       rst_n,
    cmfs_dir_if.sink   dir,
    cmfs_tex_if.source tex
);
    import cmfs_pkg::*;

    // Front: abs of each axis, major-axis pick (X over Y over Z on ties),
    // face code and the two numerators c + m, registered.
    logic      front_valid;
    logic      front_ready;
    cmfs_job_t front_job;

    // Queue output feeding the divider pipe
    logic      back_valid;
    logic      back_ready;
    cmfs_job_t back_job;

    cmfs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .dir       (dir),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    // Short queue decouples classification from the divider so a stalled
    // tex sink does not ripple straight back to dir in the same cycle.
    cmfs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_job),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_data  (back_job)
    );

    // Back: coord = round((c/m + 1)/2 * 2^UV), saturated; a zero vector
    // gives the face-center value and the degenerate flag.
    cmfs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .tex       (tex)
    );

endmodule
